// ===== src/isotp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package isotp_pkg;

  // Result kinds on the output channel
  typedef enum logic [1:0] {
    RK_PIECE = 2'd0,
    RK_FLOW  = 2'd1,
    RK_ERROR = 2'd2
  } result_kind_t;

  // Error report codes
  typedef enum logic [2:0] {
    ERR_SF_LENGTH  = 3'd0,
    ERR_FF_SHORT   = 3'd1,
    ERR_FF_LENGTH  = 3'd2,
    ERR_UNEXP_CF   = 3'd3,
    ERR_SEQUENCE   = 3'd4,
    ERR_TIMEOUT    = 3'd5,
    ERR_UNKNOWN    = 3'd6
  } err_code_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_RESP_ID    = 2'd0,
    CFG_BLOCK_SIZE = 2'd1,
    CFG_SEP_TIME   = 2'd2,
    CFG_TIMEOUT    = 2'd3
  } cfg_reg_t;

  // Protocol control info frame types (upper nibble of byte 0)
  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;
  localparam logic [3:0] PCI_FC = 4'h3;

  localparam logic       CMD_FRAME = 1'b0;
  localparam logic       CMD_TICK  = 1'b1;

  localparam logic [7:0]  FC_CTS_BYTE     = 8'h30;
  localparam logic [3:0]  MAX_FRAME_LEN   = 4'd8;
  localparam logic [11:0] MIN_FF_LENGTH   = 12'd8;
  localparam logic [15:0] TICK_SATURATE   = 16'hFFFF;

  localparam logic [28:0] RESP_ID_RESET    = 29'd0;
  localparam logic [7:0]  BLOCK_SIZE_RESET = 8'd8;
  localparam logic [7:0]  SEP_TIME_RESET   = 8'd0;
  localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // One classified item: a piece or error, optionally followed by flow control
  typedef struct packed {
    logic         with_flow;
    result_kind_t kind;
    logic [55:0]  payload_bytes;
    logic [2:0]   payload_count;
    logic         first_piece;
    logic         message_done;
    logic         single_frame;
    logic [11:0]  message_length;
    err_code_t    error_code;
  } job_t;

  // Flow control frame settings
  typedef struct packed {
    logic [28:0] can_id;
    logic [7:0]  block_size;
    logic [7:0]  sep_time;
  } fc_cfg_t;

  // Keep the leading count bytes of a 56-bit payload, clear the rest
  function automatic logic [55:0] keep_bytes(logic [55:0] v, logic [2:0] count);
    logic [55:0] mask;
    mask = ~({56{1'b1}} >> {count, 3'b000});
    return v & mask;
  endfunction

endpackage

`default_nettype wire

// ===== src/isotp_receive_reassembler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Ports                                      | Beat accepted when
// ---------+--------------------------------------------+---------------------
// input    | in_push, in_full, in_command, in_frame_*   | in_push && !in_full
// result   | out_pop, out_empty, out_* payload          | out_pop && !out_empty
// config   | cfg_we, cfg_index, cfg_data                | cfg_we
//
// One input beat per cycle while in_full is low; the front classifies
// and updates reassembly state in the accept cycle. Its result goes
// through the job queue into the output register. A first frame
// yields two result beats; while out_pop is held, the single output
// register gives one item per cycle for one-result items and holds a
// first frame for both beats. A 4-entry job queue absorbs bursts.
// Reset is synchronous, active low; in_full rises only when the queue fills.
module isotp_receive_reassembler import isotp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic        in_command,
  input  wire logic [63:0] in_frame_bytes,
  input  wire logic [3:0]  in_frame_length,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_result_kind,
  output logic [55:0]      out_payload_bytes,
  output logic [2:0]       out_payload_count,
  output logic             out_first_piece,
  output logic             out_message_done,
  output logic             out_single_frame,
  output logic [11:0]      out_message_length,
  output logic [28:0]      out_send_can_id,
  output logic [63:0]      out_send_frame,
  output logic [2:0]       out_error_code,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [28:0] cfg_data
);

  logic [28:0] resp_id_r;
  logic [7:0]  block_size_r;
  logic [7:0]  sep_time_r;
  logic [15:0] timeout_ms_r;

  fc_cfg_t fc_cfg;
  job_t    push_job;
  job_t    pop_job;
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_id_r    <= RESP_ID_RESET;
      block_size_r <= BLOCK_SIZE_RESET;
      sep_time_r   <= SEP_TIME_RESET;
      timeout_ms_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESP_ID:    resp_id_r    <= cfg_data;
        CFG_BLOCK_SIZE: block_size_r <= cfg_data[7:0];
        CFG_SEP_TIME:   sep_time_r   <= cfg_data[7:0];
        CFG_TIMEOUT:    timeout_ms_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign fc_cfg.can_id     = resp_id_r;
  assign fc_cfg.block_size = block_size_r;
  assign fc_cfg.sep_time   = sep_time_r;
  assign in_full           = q_full;

  isotp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .q_full          (q_full),
    .in_command      (in_command),
    .in_frame_bytes  (in_frame_bytes),
    .in_frame_length (in_frame_length),
    .timeout_ms      (timeout_ms_r),
    .q_push          (q_push),
    .q_job           (push_job)
  );

  isotp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  isotp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_job              (pop_job),
    .q_pop              (q_pop),
    .fc_cfg             (fc_cfg),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_result_kind    (out_result_kind),
    .out_payload_bytes  (out_payload_bytes),
    .out_payload_count  (out_payload_count),
    .out_first_piece    (out_first_piece),
    .out_message_done   (out_message_done),
    .out_single_frame   (out_single_frame),
    .out_message_length (out_message_length),
    .out_send_can_id    (out_send_can_id),
    .out_send_frame     (out_send_frame),
    .out_error_code     (out_error_code),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire

// ===== src/isotp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isotp_front import isotp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire logic        q_full,
  input  wire logic        in_command,
  input  wire logic [63:0] in_frame_bytes,
  input  wire logic [3:0]  in_frame_length,
  input  wire logic [15:0] timeout_ms,
  output logic             q_push,
  output job_t             q_job
);

  logic        reassembling_r, reassembling_nxt;
  logic [3:0]  exp_seq_r, exp_seq_nxt;
  logic [11:0] total_len_r, total_len_nxt;
  logic [12:0] recv_cnt_r, recv_cnt_nxt;
  logic [15:0] idle_ticks_r, idle_ticks_nxt;

  logic        accept;
  logic [3:0]  len_c;
  logic [7:0]  b0;
  logic [3:0]  sf_len;
  logic [11:0] ff_total;
  logic [15:0] idle_inc;
  logic [12:0] remaining;
  logic [2:0]  cf_cnt;
  logic [12:0] recv_new;
  logic [3:0]  seq_inc;

  assign accept = in_push && !q_full;

  // Classify the beat and compute the next reassembly state
  always_comb begin
    reassembling_nxt = reassembling_r;
    exp_seq_nxt      = exp_seq_r;
    total_len_nxt    = total_len_r;
    recv_cnt_nxt     = recv_cnt_r;
    idle_ticks_nxt   = idle_ticks_r;
    q_push           = 1'b0;
    q_job            = '0;

    len_c    = (in_frame_length > MAX_FRAME_LEN) ? MAX_FRAME_LEN : in_frame_length;
    b0       = in_frame_bytes[63:56];
    sf_len   = b0[3:0];
    ff_total = {b0[3:0], in_frame_bytes[55:48]};
    idle_inc = (idle_ticks_r < TICK_SATURATE) ? idle_ticks_r + 16'd1 : idle_ticks_r;
    remaining = ({1'b0, total_len_r} > recv_cnt_r) ?
                ({1'b0, total_len_r} - recv_cnt_r) : 13'd0;
    cf_cnt   = 3'(len_c - 4'd1);
    if ({10'd0, cf_cnt} > remaining) begin
      cf_cnt = remaining[2:0];
    end
    recv_new = recv_cnt_r + {10'd0, cf_cnt};
    seq_inc  = exp_seq_r + 4'd1;
    if (seq_inc == 4'd0) begin
      seq_inc = 4'd1;
    end

    if (accept) begin
      if (in_command == CMD_TICK) begin
        // Count ticks while reassembling, abort on timeout
        if (reassembling_r) begin
          if (idle_inc >= timeout_ms) begin
            reassembling_nxt = 1'b0;
            idle_ticks_nxt   = 16'd0;
            q_push           = 1'b1;
            q_job.kind       = RK_ERROR;
            q_job.error_code = ERR_TIMEOUT;
          end else begin
            idle_ticks_nxt = idle_inc;
          end
        end
      end else if (len_c != 4'd0) begin
        unique case (b0[7:4])
          PCI_SF: begin
            q_push = 1'b1;
            if (sf_len == 4'd0 || sf_len + 4'd1 != len_c) begin
              q_job.kind       = RK_ERROR;
              q_job.error_code = ERR_SF_LENGTH;
            end else begin
              q_job.kind           = RK_PIECE;
              q_job.payload_count  = sf_len[2:0];
              q_job.payload_bytes  = keep_bytes(in_frame_bytes[55:0], sf_len[2:0]);
              q_job.first_piece    = 1'b1;
              q_job.message_done   = 1'b1;
              q_job.single_frame   = 1'b1;
              q_job.message_length = {8'd0, sf_len};
            end
          end
          PCI_FF: begin
            q_push = 1'b1;
            if (len_c < 4'd2) begin
              q_job.kind       = RK_ERROR;
              q_job.error_code = ERR_FF_SHORT;
            end else if (ff_total < MIN_FF_LENGTH) begin
              q_job.kind       = RK_ERROR;
              q_job.error_code = ERR_FF_LENGTH;
            end else begin
              // Start reassembly, then answer with clear to send
              total_len_nxt    = ff_total;
              recv_cnt_nxt     = {9'd0, len_c - 4'd2};
              exp_seq_nxt      = 4'd1;
              reassembling_nxt = 1'b1;
              idle_ticks_nxt   = 16'd0;
              q_job.with_flow      = 1'b1;
              q_job.kind           = RK_PIECE;
              q_job.payload_count  = 3'(len_c - 4'd2);
              q_job.payload_bytes  = keep_bytes({in_frame_bytes[47:0], 8'h00},
                                                3'(len_c - 4'd2));
              q_job.first_piece    = 1'b1;
              q_job.message_length = ff_total;
            end
          end
          PCI_CF: begin
            q_push = 1'b1;
            if (!reassembling_r) begin
              q_job.kind       = RK_ERROR;
              q_job.error_code = ERR_UNEXP_CF;
            end else if (b0[3:0] != exp_seq_r) begin
              reassembling_nxt = 1'b0;
              idle_ticks_nxt   = 16'd0;
              q_job.kind       = RK_ERROR;
              q_job.error_code = ERR_SEQUENCE;
            end else begin
              recv_cnt_nxt   = recv_new;
              exp_seq_nxt    = seq_inc;
              idle_ticks_nxt = 16'd0;
              if (recv_new >= {1'b0, total_len_r}) begin
                reassembling_nxt = 1'b0;
              end
              q_job.kind           = RK_PIECE;
              q_job.payload_count  = cf_cnt;
              q_job.payload_bytes  = keep_bytes(in_frame_bytes[55:0], cf_cnt);
              q_job.message_done   = (recv_new >= {1'b0, total_len_r});
              q_job.message_length = total_len_r;
            end
          end
          PCI_FC: begin
            // Flow control for the transmit side: drop
          end
          default: begin
            q_push           = 1'b1;
            q_job.kind       = RK_ERROR;
            q_job.error_code = ERR_UNKNOWN;
          end
        endcase
      end
    end
  end

  // Hold reassembly state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reassembling_r <= 1'b0;
      exp_seq_r      <= 4'd1;
      total_len_r    <= 12'd0;
      recv_cnt_r     <= 13'd0;
      idle_ticks_r   <= 16'd0;
    end else begin
      reassembling_r <= reassembling_nxt;
      exp_seq_r      <= exp_seq_nxt;
      total_len_r    <= total_len_nxt;
      recv_cnt_r     <= recv_cnt_nxt;
      idle_ticks_r   <= idle_ticks_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/isotp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isotp_queue import isotp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_job,
  output logic      empty
);

  job_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/isotp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module isotp_back import isotp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_empty,
  input  wire job_t         q_job,
  output logic              q_pop,
  input  wire fc_cfg_t      fc_cfg,
  output logic              out_empty,
  input  wire logic         out_pop,
  output logic [1:0]        out_result_kind,
  output logic [55:0]       out_payload_bytes,
  output logic [2:0]        out_payload_count,
  output logic              out_first_piece,
  output logic              out_message_done,
  output logic              out_single_frame,
  output logic [11:0]       out_message_length,
  output logic [28:0]       out_send_can_id,
  output logic [63:0]       out_send_frame,
  output logic [2:0]        out_error_code,
  output logic              out_last
);

  job_t job_r;
  logic valid_r;
  logic flow_phase_r;
  logic beat_taken;
  logic job_finish;

  assign beat_taken = out_pop && valid_r;
  assign job_finish = beat_taken && (flow_phase_r || !job_r.with_flow);
  assign q_pop      = !q_empty && (!valid_r || job_finish);
  assign out_empty  = !valid_r;

  // Load next job, step from piece to flow control beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      flow_phase_r <= 1'b0;
    end else if (q_pop) begin
      valid_r      <= 1'b1;
      flow_phase_r <= 1'b0;
    end else if (job_finish) begin
      valid_r      <= 1'b0;
      flow_phase_r <= 1'b0;
    end else if (beat_taken) begin
      flow_phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
    end
  end

  // Drive the current beat
  always_comb begin
    out_result_kind    = job_r.kind;
    out_payload_bytes  = job_r.payload_bytes;
    out_payload_count  = job_r.payload_count;
    out_first_piece    = job_r.first_piece;
    out_message_done   = job_r.message_done;
    out_single_frame   = job_r.single_frame;
    out_message_length = job_r.message_length;
    out_send_can_id    = 29'd0;
    out_send_frame     = 64'd0;
    out_error_code     = job_r.error_code;
    out_last           = !job_r.with_flow;
    if (flow_phase_r) begin
      out_result_kind    = RK_FLOW;
      out_payload_bytes  = 56'd0;
      out_payload_count  = 3'd0;
      out_first_piece    = 1'b0;
      out_message_done   = 1'b0;
      out_single_frame   = 1'b0;
      out_message_length = 12'd0;
      out_send_can_id    = fc_cfg.can_id;
      out_send_frame     = {FC_CTS_BYTE, fc_cfg.block_size, fc_cfg.sep_time, 40'd0};
      out_error_code     = ERR_SF_LENGTH;
      out_last           = 1'b1;
    end
  end

endmodule

`default_nettype wire
